[sv/lts_pkg.sv]
// Shared types and constants for the triangle/sawtooth LFO modulator.
package lts_pkg;

  localparam int unsigned VAL_W      = 12;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned OBUF_DEPTH = 3;
  localparam int unsigned OBUF_PTR_W = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_WAVE_SHAPE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_MOD_DEPTH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_CUTOFF_BASE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_PW1_BASE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_PW2_BASE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_PW3_BASE     = 3'd5;
  localparam logic [IDX_W-1:0] REG_CUTOFF_LIMIT = 3'd6;
  localparam logic [IDX_W-1:0] REG_PW_LIMIT     = 3'd7;

  localparam logic [VAL_W-1:0] CUTOFF_LIMIT_RST = 12'd2047;
  localparam logic [VAL_W-1:0] PW_LIMIT_RST     = 12'd4095;

  // Request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_ROUTE = 1'b1;

  // Command codes
  localparam logic [3:0] CMD_OFF          = 4'd0;
  localparam logic [3:0] CMD_CUTOFF       = 4'd1;
  localparam logic [3:0] CMD_PW1          = 4'd2;
  localparam logic [3:0] CMD_PW2          = 4'd3;
  localparam logic [3:0] CMD_PW3          = 4'd4;
  localparam logic [3:0] CMD_PW_ALL       = 4'd5;
  localparam logic [3:0] CMD_OTHER_FIRST  = 4'd6;
  localparam logic [3:0] CMD_LAST_ROUTE   = 4'd10;
  localparam logic [3:0] CMD_RESTART_LAST = 4'd14;

  // Per-destination oscillator steps
  localparam logic [5:0] STEP_CUTOFF = 6'd20;
  localparam logic [5:0] STEP_PW     = 6'd50;
  localparam logic [5:0] STEP_OTHER  = 6'd1;

  // Result targets
  localparam logic [2:0] TGT_CUTOFF = 3'd0;
  localparam logic [2:0] TGT_PW1    = 3'd1;
  localparam logic [2:0] TGT_PW2    = 3'd2;
  localparam logic [2:0] TGT_PW3    = 3'd3;
  localparam logic [2:0] TGT_PW_ALL = 3'd4;

  typedef struct packed {
    logic             wave_shape;
    logic [7:0]       mod_depth;
    logic [VAL_W-1:0] cutoff_base;
    logic [VAL_W-1:0] pw1_base;
    logic [VAL_W-1:0] pw2_base;
    logic [VAL_W-1:0] pw3_base;
    logic [VAL_W-1:0] cutoff_limit;
    logic [VAL_W-1:0] pw_limit;
  } lts_cfg_t;

  typedef struct packed {
    logic [2:0]       target;
    logic [VAL_W-1:0] value_a;
    logic [VAL_W-1:0] value_b;
    logic [VAL_W-1:0] value_c;
  } lts_res_t;

  typedef struct packed {
    logic     valid;
    lts_res_t data;
  } lts_res_beat_t;

endpackage

[sv/lfo_triangle_saw_modulator.sv]
// An accepted beat is registered in the input stage; the oscillator update and the write of
// its result into the result queue happen as it leaves that stage, and the queue then offers it.
// Throughput: one beat per cycle while the result queue has room (in_ready);
// a three-entry result queue keeps input accepting while results wait.
// Reset (rst, synchronous): registers to defaults, oscillator off, queue empty.
module lfo_triangle_saw_modulator import lts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [3:0]       command_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       target,
  output logic [VAL_W-1:0] value_a,
  output logic [VAL_W-1:0] value_b,
  output logic [VAL_W-1:0] value_c,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0] cfg_data
);

  lts_cfg_t              cfg;
  logic                  s0_valid;
  logic                  s0_req;
  logic [3:0]            s0_cmd;
  lts_res_beat_t         core_res;
  lts_res_t              q_data;
  logic [OBUF_PTR_W-1:0] q_level;

  // leave room for the beat in flight plus the one being accepted
  assign in_ready = ({1'b0, q_level} + {{OBUF_PTR_W{1'b0}}, s0_valid})
                    < (OBUF_PTR_W + 1)'(OBUF_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_shape   <= 1'b0;
      cfg.mod_depth    <= '0;
      cfg.cutoff_base  <= '0;
      cfg.pw1_base     <= '0;
      cfg.pw2_base     <= '0;
      cfg.pw3_base     <= '0;
      cfg.cutoff_limit <= CUTOFF_LIMIT_RST;
      cfg.pw_limit     <= PW_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WAVE_SHAPE:   cfg.wave_shape   <= cfg_data[0];
        REG_MOD_DEPTH:    cfg.mod_depth    <= cfg_data[7:0];
        REG_CUTOFF_BASE:  cfg.cutoff_base  <= cfg_data;
        REG_PW1_BASE:     cfg.pw1_base     <= cfg_data;
        REG_PW2_BASE:     cfg.pw2_base     <= cfg_data;
        REG_PW3_BASE:     cfg.pw3_base     <= cfg_data;
        REG_CUTOFF_LIMIT: cfg.cutoff_limit <= cfg_data;
        REG_PW_LIMIT:     cfg.pw_limit     <= cfg_data;
        default:          cfg.wave_shape   <= cfg.wave_shape;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_req <= req_type;
      s0_cmd <= command_code;
    end
  end

  lts_core u_core (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (s0_valid),
    .req        (s0_req),
    .cmd        (s0_cmd),
    .cfg        (cfg),
    .res        (core_res)
  );

  lts_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (core_res.valid),
    .push_data (core_res.data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data),
    .level     (q_level)
  );

  assign target  = q_data.target;
  assign value_a = q_data.value_a;
  assign value_b = q_data.value_b;
  assign value_c = q_data.value_c;

endmodule

[sv/lts_core.sv]
// Oscillator state and the per-beat tick/command update with clipped results.
module lts_core import lts_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          beat_valid,
  input  logic          req,
  input  logic [3:0]    cmd,
  input  lts_cfg_t      cfg,
  output lts_res_beat_t res
);

  logic signed [15:0] mod_accum;
  logic signed [7:0]  step_now;
  logic               direction_flag;  // 1: falling
  logic               osc_enabled;
  logic [3:0]         destination;

  logic signed [15:0] mod_accum_next;
  logic signed [7:0]  step_now_next;
  logic               direction_flag_next;

  logic [5:0]         ds;
  logic signed [15:0] acc_add;
  logic [13:0]        tri_prod;
  logic signed [15:0] tri_lim;
  logic signed [16:0] saw_prod;
  logic signed [16:0] saw_adj;
  logic signed [16:0] saw_half;
  logic signed [15:0] saw_lim;
  logic signed [17:0] acc_ext;
  logic signed [17:0] depth_term;
  logic signed [17:0] sum_cut;
  logic signed [17:0] sum_pw1;
  logic signed [17:0] sum_pw2;
  logic signed [17:0] sum_pw3;
  logic               tick_on;

  function automatic logic [5:0] dest_step(input logic [3:0] d);
    logic [5:0] s;
    case (d) inside
      CMD_CUTOFF:                        s = STEP_CUTOFF;
      [CMD_PW1:CMD_PW_ALL]:              s = STEP_PW;
      [CMD_OTHER_FIRST:CMD_LAST_ROUTE]:  s = STEP_OTHER;
      default:                           s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic logic [VAL_W-1:0] clip(input logic signed [17:0] v,
                                            input logic [VAL_W-1:0] lim);
    logic [VAL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({6'b0, lim})) begin
      r = lim;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  assign ds       = dest_step(destination);
  assign acc_add  = mod_accum + {{8{step_now[7]}}, step_now};
  assign tri_prod = cfg.mod_depth * ds;
  assign tri_lim  = $signed({3'b0, tri_prod[13:1]});

  // sawtooth limit uses the live signed step; halve toward zero
  assign saw_prod = $signed({1'b0, cfg.mod_depth}) * step_now;
  assign saw_adj  = saw_prod + $signed({16'b0, saw_prod[16]});
  assign saw_half = saw_adj >>> 1;
  assign saw_lim  = saw_half[15:0];

  always_comb begin
    mod_accum_next      = acc_add;
    step_now_next       = step_now;
    direction_flag_next = direction_flag;
    if (!cfg.wave_shape) begin
      if (acc_add >= tri_lim) begin
        direction_flag_next = 1'b1;
        step_now_next       = 8'd0 - {2'b0, ds};
      end else if (acc_add <= -tri_lim) begin
        direction_flag_next = 1'b0;
        step_now_next       = {2'b0, ds};
      end
    end else if (acc_add >= saw_lim) begin
      mod_accum_next = -saw_lim;
    end
  end

  assign acc_ext    = {{2{mod_accum_next[15]}}, mod_accum_next};
  assign depth_term = direction_flag_next ? -$signed({10'b0, cfg.mod_depth})
                                          :  $signed({10'b0, cfg.mod_depth});
  assign sum_cut = $signed({6'b0, cfg.cutoff_base}) + acc_ext + depth_term;
  assign sum_pw1 = $signed({6'b0, cfg.pw1_base}) + acc_ext;
  assign sum_pw2 = $signed({6'b0, cfg.pw2_base}) + acc_ext;
  assign sum_pw3 = $signed({6'b0, cfg.pw3_base}) + acc_ext;

  assign tick_on = beat_valid && (req == REQ_TICK) && osc_enabled;

  always_comb begin
    res.valid        = 1'b0;
    res.data.target  = TGT_CUTOFF;
    res.data.value_a = '0;
    res.data.value_b = '0;
    res.data.value_c = '0;
    case (destination)
      CMD_CUTOFF: begin
        res.valid        = tick_on;
        res.data.value_a = clip(sum_cut, cfg.cutoff_limit);
      end
      CMD_PW1: begin
        res.valid        = tick_on;
        res.data.target  = TGT_PW1;
        res.data.value_a = clip(sum_pw1, cfg.pw_limit);
      end
      CMD_PW2: begin
        res.valid        = tick_on;
        res.data.target  = TGT_PW2;
        res.data.value_a = clip(sum_pw2, cfg.pw_limit);
      end
      CMD_PW3: begin
        res.valid        = tick_on;
        res.data.target  = TGT_PW3;
        res.data.value_a = clip(sum_pw3, cfg.pw_limit);
      end
      CMD_PW_ALL: begin
        res.valid        = tick_on;
        res.data.target  = TGT_PW_ALL;
        res.data.value_a = clip(sum_pw1, cfg.pw_limit);
        res.data.value_b = clip(sum_pw2, cfg.pw_limit);
        res.data.value_c = clip(sum_pw3, cfg.pw_limit);
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_accum      <= '0;
      step_now       <= '0;
      direction_flag <= 1'b0;
      osc_enabled    <= 1'b0;
      destination    <= CMD_OFF;
    end else if (beat_valid) begin
      if (req == REQ_ROUTE) begin
        if (cmd == CMD_OFF) begin
          osc_enabled <= 1'b0;
        end else if (cmd <= CMD_LAST_ROUTE) begin
          destination <= cmd;
          osc_enabled <= 1'b1;
          mod_accum   <= '0;
          step_now    <= $signed({2'b0, dest_step(cmd)});
        end else if (cmd <= CMD_RESTART_LAST) begin
          mod_accum <= '0;
          step_now  <= $signed({2'b0, ds});
        end
      end else if (osc_enabled) begin
        mod_accum      <= mod_accum_next;
        step_now       <= step_now_next;
        direction_flag <= direction_flag_next;
      end
    end
  end

endmodule

[sv/lts_obuf.sv]
// Small result queue that decouples result production from the output handshake.
module lts_obuf import lts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lts_res_t              push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lts_res_t              out_data,
  output logic [OBUF_PTR_W-1:0] level
);

  lts_res_t              slots [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] wr_ptr;
  logic [OBUF_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = (level != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (level == OBUF_PTR_W'(OBUF_DEPTH))))
    else $error("result queue overflow");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= OBUF_PTR_W'(OBUF_DEPTH))
    else $error("result queue level out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (level == $past(level) - 1'b1))
    else $error("pop without push did not lower the level");
`endif

endmodule
